/* design/sliding_window_std_dev_defines.svh */
// assertion macros shared by the rtl
`ifndef SLIDING_WINDOW_STD_DEV_DEFINES_SVH
`define SLIDING_WINDOW_STD_DEV_DEFINES_SVH

// condition implies consequence in the same cycle
`define SWSD_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("swsd assertion failed");

// condition implies consequence in the next cycle
`define SWSD_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("swsd assertion failed");

`endif

/* design/swsd_pkg.sv */
// ---------------------------------------------------------------------------
// swsd_pkg
// shared constants and state types of the moving standard deviation block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package swsd_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int CFG_W          = 9;
  localparam int VAR_W          = 48;
  localparam int WINDOW_MAX_DEF = 256;
  localparam logic [CFG_W-1:0] WL_RESET = 9'd10;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_UPD,
    TOP_CALC
  } swsd_top_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_SQRT,
    U_DONE
  } swsd_unit_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } swsd_unit_ctl_t;

endpackage
`default_nettype wire

/* design/swsd_window_mem.sv */
// ---------------------------------------------------------------------------
// swsd_window_mem
// sample ring store, one write port and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module swsd_window_mem #(
  parameter int DEPTH = swsd_pkg::WINDOW_MAX_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [swsd_pkg::SAMPLE_W-1:0] rd_data,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [swsd_pkg::SAMPLE_W-1:0] wr_data
);
  import swsd_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* design/swsd_var_unit.sv */
// ---------------------------------------------------------------------------
// swsd_var_unit
// serial n*q - s*s, restoring divide by n*n, then digit-by-digit square root
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module swsd_var_unit #(
  parameter int LW = 9,
  parameter int SW = 32,
  parameter int QW = 56
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire swsd_pkg::swsd_unit_ctl_t      ctl,
  input  wire logic [LW-1:0]                 n,
  input  wire logic [SW-1:0]                 sum,
  input  wire logic [QW-1:0]                 sq,
  output logic                               done,
  output logic      [swsd_pkg::SAMPLE_W-1:0] result
);
  import swsd_pkg::*;

  localparam int PW = LW + QW;
  localparam int DW = 2 * LW + 1;
  localparam int CW = $clog2(PW + 1);

  swsd_unit_state_t state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                phase_r, phase_nxt;
  logic [PW-1:0]       acc_r, acc_nxt;
  logic [PW-1:0]       mcand_r, mcand_nxt;
  logic [SW-1:0]       mplier_r, mplier_nxt;
  logic [2*LW-1:0]     dsr_r, dsr_nxt;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic [VAR_W-1:0]    quo_r, quo_nxt;
  logic [VAR_W-1:0]    bit_r, bit_nxt;
  logic [VAR_W-1:0]    res_r, res_nxt;
  logic [DW-1:0]       trial;
  logic [VAR_W-1:0]    rb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r    <= cnt_nxt;
    phase_r  <= phase_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    dsr_r    <= dsr_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    bit_r    <= bit_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    dsr_nxt    = dsr_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    bit_nxt    = bit_r;
    res_nxt    = res_r;
    trial      = {rem_r[DW-2:0], acc_r[PW-1]};
    rb         = res_r + bit_r;
    case (state_r)
      U_IDLE: begin
        if (ctl.start) begin
          acc_nxt    = '0;
          mcand_nxt  = PW'(sq);
          mplier_nxt = SW'(n);
          dsr_nxt    = (2*LW)'(n) * (2*LW)'(n);
          phase_nxt  = 1'b0;
          cnt_nxt    = CW'(SW);
          state_nxt  = U_MUL;
        end
      end
      U_MUL: begin
        // first pass adds n*q, second pass takes away s*s
        if (mplier_r[0]) begin
          acc_nxt = phase_r ? (acc_r - mcand_r) : (acc_r + mcand_r);
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          if (!phase_r) begin
            phase_nxt  = 1'b1;
            mcand_nxt  = PW'(sum);
            mplier_nxt = sum;
            cnt_nxt    = CW'(SW);
          end else begin
            rem_nxt   = '0;
            quo_nxt   = '0;
            cnt_nxt   = CW'(PW);
            state_nxt = U_DIV;
          end
        end
      end
      U_DIV: begin
        if (trial >= DW'(dsr_r)) begin
          rem_nxt = trial - DW'(dsr_r);
          quo_nxt = {quo_r[VAR_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[VAR_W-2:0], 1'b0};
        end
        acc_nxt = acc_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          res_nxt   = '0;
          bit_nxt   = VAR_W'(1) << (VAR_W - 2);
          state_nxt = U_SQRT;
        end
      end
      U_SQRT: begin
        if (quo_r >= rb) begin
          quo_nxt = quo_r - rb;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = U_DONE;
        end
      end
      U_DONE: begin
        if (ctl.ack) begin
          state_nxt = U_IDLE;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  assign done   = (state_r == U_DONE);
  assign result = res_r[SAMPLE_W-1:0];

endmodule
`default_nettype wire

/* design/sliding_window_std_dev.sv */
// ---------------------------------------------------------------------------
// sliding_window_std_dev
// moving population standard deviation over the last n samples, q16.8
// ---------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries in_sample and in_series_start;
//   series_start drops the history before the sample is taken.
//   result channel out_valid/out_ready carries out_std_dev, one result per
//   sample once the window holds n samples of the current series.
//   cfg_wr_en/cfg_wr_data set the window length (saturated to 2..WINDOW_MAX)
//   and clear the history; write only while the block is idle.
// operation:
//   a sample with no result passes through the ring read, then the update.
//   a sample with a result then goes through the serial multiply, the
//   bit-serial divide and the square root, all in one shared unit; one
//   sample is in work at a time. its result is loaded into the output
//   register and shows on out_valid once that register is free.
// reset: history empty, window length 10; the ring needs no clearing pass.
// stall: a finished result waits in the output register while the next
//   sample is taken; the unit holds its result until that register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_std_dev_defines.svh"
module sliding_window_std_dev #(
  parameter int WINDOW_MAX = swsd_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [swsd_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          in_series_start,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [swsd_pkg::SAMPLE_W-1:0] out_std_dev,
  input  wire logic                          cfg_wr_en,
  input  wire logic [swsd_pkg::CFG_W-1:0]    cfg_wr_data
);
  import swsd_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int SW = SAMPLE_W + AW;
  localparam int QW = 2 * SAMPLE_W + AW;
  localparam int XW = (LW > CFG_W) ? LW : CFG_W;

  swsd_top_state_t state_r, state_nxt;
  logic [CFG_W-1:0]    wl_r;
  logic [LW-1:0]       n_eff;
  logic [AW-1:0]       ws_r, ws_nxt;
  logic [LW-1:0]       fc_r, fc_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic [QW-1:0]       sq_r, sq_nxt;
  logic [SAMPLE_W-1:0] x_r;
  logic [2*SAMPLE_W-1:0] xsq_r;
  logic [AW-1:0]       slot_r;
  logic                full_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;
  logic                accept;
  logic [AW-1:0]       ws_in;
  logic [LW-1:0]       fc_in;
  logic [AW-1:0]       slot_in;
  logic [SAMPLE_W-1:0] old;
  logic [2*SAMPLE_W-1:0] old_sq;
  logic [AW:0]         slot_inc;
  logic                out_free;
  swsd_unit_ctl_t      u_ctl;
  logic                u_done;
  logic [SAMPLE_W-1:0] u_result;

  always_comb begin
    if (wl_r < CFG_W'(2)) begin
      n_eff = LW'(2);
    end else if (XW'(wl_r) > XW'(WINDOW_MAX)) begin
      n_eff = LW'(WINDOW_MAX);
    end else begin
      n_eff = LW'(wl_r);
    end
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == TOP_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign ws_in    = in_series_start ? '0 : ws_r;
  assign fc_in    = in_series_start ? '0 : fc_r;
  assign slot_in  = (LW'(ws_in) >= n_eff) ? '0 : ws_in;
  assign old_sq   = old * old;
  assign slot_inc = (AW+1)'(slot_r) + 1'b1;

  swsd_window_mem #(.DEPTH(WINDOW_MAX), .AW(AW)) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (slot_in),
    .rd_data (old),
    .wr_en   (state_r == TOP_UPD),
    .wr_addr (slot_r),
    .wr_data (x_r)
  );

  swsd_var_unit #(.LW(LW), .SW(SW), .QW(QW)) u_var (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (u_ctl),
    .n      (n_eff),
    .sum    (sum_r),
    .sq     (sq_r),
    .done   (u_done),
    .result (u_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TOP_IDLE;
      wl_r        <= WL_RESET;
      ws_r        <= '0;
      fc_r        <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ws_r    <= ws_nxt;
      fc_r    <= fc_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      if (cfg_wr_en) begin
        wl_r <= cfg_wr_data;
      end
      if (u_ctl.ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      x_r    <= in_sample;
      xsq_r  <= in_sample * in_sample;
      slot_r <= slot_in;
      full_r <= (fc_in >= n_eff);
    end
    if (u_ctl.ack) begin
      out_data_r <= u_result;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ws_nxt      = ws_r;
    fc_nxt      = fc_r;
    sum_nxt     = sum_r;
    sq_nxt      = sq_r;
    u_ctl.start = 1'b0;
    u_ctl.ack   = 1'b0;
    case (state_r)
      TOP_IDLE: begin
        if (cfg_wr_en) begin
          ws_nxt  = '0;
          fc_nxt  = '0;
          sum_nxt = '0;
          sq_nxt  = '0;
        end else if (accept) begin
          // a series start drops the history ahead of this request
          ws_nxt = ws_in;
          fc_nxt = fc_in;
          if (in_series_start) begin
            sum_nxt = '0;
            sq_nxt  = '0;
          end
          state_nxt = TOP_UPD;
        end
      end
      TOP_UPD: begin
        if (full_r) begin
          sum_nxt = sum_r - SW'(old) + SW'(x_r);
          sq_nxt  = sq_r - QW'(old_sq) + QW'(xsq_r);
          fc_nxt  = n_eff;
        end else begin
          sum_nxt = sum_r + SW'(x_r);
          sq_nxt  = sq_r + QW'(xsq_r);
          fc_nxt  = fc_r + 1'b1;
        end
        ws_nxt = ((LW+1)'(slot_inc) >= (LW+1)'(n_eff)) ? '0 : slot_inc[AW-1:0];
        if (full_r || (fc_r + 1'b1 >= n_eff)) begin
          state_nxt = TOP_CALC;
        end else begin
          state_nxt = TOP_IDLE;
        end
      end
      TOP_CALC: begin
        u_ctl.start = 1'b1;
        if (u_done && out_free) begin
          u_ctl.ack   = 1'b1;
          u_ctl.start = 1'b0;
          state_nxt   = TOP_IDLE;
        end
      end
      default: state_nxt = TOP_IDLE;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_std_dev = out_data_r;

  `SWSD_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fc_r <= n_eff)
  `SWSD_ASSERT_NEXT(a_accept_upd, clk, rst_n, accept, state_r == TOP_UPD)
  `SWSD_ASSERT_SAME(a_ack_free, clk, rst_n, u_ctl.ack, u_done && out_free)

endmodule
`default_nettype wire

/* tb/tb_sliding_window_std_dev.sv */
// ---------------------------------------------------------------------------
// tb_sliding_window_std_dev
// self-checking bench for the moving population standard deviation block:
// a local model of the window keeps its own ring, sums and length, predicts
// each result when a request is accepted, and a checker compares the results
// in order under random idling on both channels and several window lengths
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_sliding_window_std_dev;
  import swsd_pkg::*;

  localparam int WIN_MAX    = WINDOW_MAX_DEF;
  localparam int IDLE_LIMIT = 8000;
  localparam int HOLD_LEN   = 600;
  localparam int SETTLE     = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                in_series_start = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SAMPLE_W-1:0] out_std_dev;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;

  sliding_window_std_dev dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .in_series_start(in_series_start),
    .out_valid(out_valid), .out_ready(out_ready), .out_std_dev(out_std_dev),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local copy of the window state
  logic [SAMPLE_W-1:0] ring [WIN_MAX];
  int                  ring_slot;
  int                  ring_fill;
  logic [63:0]         sum_x;
  logic [63:0]         sum_xx;
  logic [CFG_W-1:0]    length_reg = WL_RESET;

  logic [SAMPLE_W-1:0] std_dev_q [$];
  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int window_n();
    if (length_reg < 2) return 2;
    if (length_reg > WIN_MAX) return WIN_MAX;
    return int'(length_reg);
  endfunction

  function automatic void clear_window();
    ring_slot = 0;
    ring_fill = 0;
    sum_x = 0;
    sum_xx = 0;
  endfunction

  // advance the window by one sample, queue a result once it is full
  function automatic void window_step(logic [SAMPLE_W-1:0] x, logic restart);
    int n;
    logic [127:0] nq, ss, v;
    logic [63:0] old;
    n = window_n();
    if (restart) clear_window();
    if (ring_slot >= n) ring_slot = 0;
    if (ring_fill >= n) begin
      old = 64'(ring[ring_slot]);
      sum_x = sum_x - old;
      sum_xx = sum_xx - old * old;
      ring_fill = n;
    end else begin
      ring_fill++;
    end
    ring[ring_slot] = x;
    sum_x = sum_x + 64'(x);
    sum_xx = sum_xx + 64'(x) * 64'(x);
    ring_slot = (ring_slot + 1 >= n) ? 0 : ring_slot + 1;
    if (ring_fill >= n) begin
      nq = 128'(n) * 128'(sum_xx);
      ss = 128'(sum_x) * 128'(sum_x);
      v = (nq - ss) / (128'(n) * 128'(n));
      std_dev_q.insert(std_dev_q.size(), SAMPLE_W'(isqrt(v[63:0])));
    end
  endfunction

  // send one request; in_valid stays high unless a gap is drawn
  task automatic send_sample(logic [SAMPLE_W-1:0] x, logic restart);
    bit fire;
    in_valid <= 1'b1;
    in_sample <= x;
    in_series_start <= restart;
    fire = 0;
    while (!fire) begin
      @(negedge clk);
      fire = in_ready;
      @(posedge clk);
    end
    window_step(x, restart);
    samples_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (std_dev_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_length(logic [CFG_W-1:0] len);
    drain(SETTLE);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    length_reg = len;
    clear_window();
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 46; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 46; end
      default: begin send_idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin : result_sink
    static int hold_cnt = 0;
    if (hold_req) begin
      hold_cnt = HOLD_LEN;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // outputs are stable at the falling edge, so results are checked there
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (std_dev_q.size() == 0) begin
        $error("unexpected result std_dev=%0h", out_std_dev);
        errors++;
      end else begin
        if (out_std_dev !== std_dev_q[0]) begin
          $error("field std_dev: expected %0h actual %0h", std_dev_q[0], out_std_dev);
          errors++;
        end
        void'(std_dev_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin : watchdog
    static int quiet = 0;
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("sliding_window_std_dev: mismatch");
      $finish;
    end
  end

  task automatic test_extremes();
    write_length(9'd2);
    send_sample(24'h000000, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h000000, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    // constant series gives zero
    send_sample(24'h123456, 1'b1);
    send_sample(24'h123456, 1'b0);
    send_sample(24'h123456, 1'b0);
  endtask

  task automatic test_series_start();
    write_length(9'd3);
    for (int i = 0; i < 5; i++) send_sample(SAMPLE_W'(i * 1000), 1'b0);
    send_sample(24'hAAAAAA, 1'b1);
    send_sample(24'h555555, 1'b0);
    send_sample(24'h000001, 1'b0);
    send_sample(24'h800000, 1'b0);
  endtask

  task automatic test_length_saturation();
    write_length(9'd0);
    send_sample(24'h000100, 1'b0);
    send_sample(24'h000300, 1'b0);
    write_length(9'd1);
    send_sample(24'hFFFF00, 1'b0);
    send_sample(24'h000000, 1'b0);
    write_length(9'd511);
    for (int i = 0; i < WIN_MAX + 3; i++) send_sample(SAMPLE_W'($urandom), 1'b0);
    write_length(9'd256);
    for (int i = 0; i < WIN_MAX + 2; i++) send_sample(24'hFFFFFF, 1'b0);
  endtask

  task automatic test_backpressure();
    write_length(9'd2);
    set_idling(0);
    send_sample(24'h000010, 1'b0);
    hold_req = 1;
    for (int i = 0; i < 40; i++) send_sample(SAMPLE_W'($urandom), 1'b0);
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] len;
    logic [SAMPLE_W-1:0] x, base;
    for (int blk = 0; blk < 20; blk++) begin
      len = (blk % 6 == 5) ? CFG_W'($urandom_range(40, 17))
                           : CFG_W'($urandom_range(16, 2));
      write_length(len);
      set_idling(blk);
      base = SAMPLE_W'($urandom);
      for (int i = 0; i < 36; i++) begin
        // mostly prices near a level, sometimes full-range noise
        if ($urandom_range(9) == 0) x = SAMPLE_W'($urandom);
        else x = base ^ SAMPLE_W'($urandom_range(4095));
        send_sample(x, $urandom_range(19) == 0);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset length of ten before any write
    for (int i = 0; i < 12; i++) send_sample(SAMPLE_W'($urandom), 1'b0);
    test_extremes();
    test_series_start();
    test_length_saturation();
    test_backpressure();
    test_random();
    drain(SETTLE);
    $display("run covered %0d samples and %0d results over lengths 2..256,", samples_sent,
             results_seen);
    $display("series restarts, saturated lengths, idling on both sides and a long stall");
    if (errors == 0) begin
      $display("sliding_window_std_dev: match");
    end else begin
      $display("sliding_window_std_dev: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
